@@ rtl/core/tmft_pkg.sv @@
`timescale 1ns / 1ps

package tmft_pkg;

    // table geometry
    localparam int SLOTS     = 40;
    localparam int TILE_BITS = 12;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);

    // position is 32 bits, 8192 units per tile: bits 30..13 are the tile number
    localparam int POS_SHIFT = 13;
    localparam int PTILE_W   = 31 - POS_SHIFT;
    localparam int BND_W     = PTILE_W + 1;

    localparam int MAP_W     = 13;

    localparam logic [14:0] CHANCE_LIMIT = 15'd5000;
    localparam logic [7:0]  BLOCK_MASK   = 8'hE0;

    // configuration register indexes
    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    // outcome codes
    localparam logic [2:0] OUT_OFF_MAP   = 3'd0;
    localparam logic [2:0] OUT_CHANCE    = 3'd1;
    localparam logic [2:0] OUT_BLOCKED   = 3'd2;
    localparam logic [2:0] OUT_HIT       = 3'd3;
    localparam logic [2:0] OUT_NEW       = 3'd4;
    localparam logic [2:0] OUT_RECYCLE   = 3'd5;
    localparam logic [2:0] OUT_NO_SPRITE = 3'd6;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [14:0]        chance_value;
        logic [7:0]         tile_flags;
        logic               sprite_available;
    } ev_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [5:0]  slot_index;
        logic [2:0]  variant;
        logic [11:0] tile_x;
        logic [11:0] tile_y;
    } res_t;

    typedef struct packed {
        logic [TILE_BITS-1:0] tag_x;
        logic [TILE_BITS-1:0] tag_y;
        logic [2:0]           variant;
    } slot_entry_t;

    // map size limited to what a tag can number
    function automatic logic [BND_W-1:0] clamp_tiles(logic [MAP_W-1:0] tiles);
        logic [BND_W-1:0] lim;
        logic [BND_W-1:0] ext;
        lim = BND_W'(1) << TILE_BITS;
        ext = BND_W'(tiles);
        return (ext > lim) ? lim : ext;
    endfunction

    function automatic logic on_map(logic [31:0] pos, logic [MAP_W-1:0] tiles);
        return !pos[31] && (BND_W'(pos[30:POS_SHIFT]) < clamp_tiles(tiles));
    endfunction

endpackage

@@ rtl/core/tmft_ram.sv @@
`timescale 1ns / 1ps

module tmft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/tile_marker_fifo_table.sv @@
`timescale 1ns / 1ps

// channel   | handshake               | word
// ----------+-------------------------+-------------------------------------
// event in  | start & !busy           | ev  (tmft_pkg::ev_t)
// result    | done, one-cycle strobe  | res (tmft_pkg::res_t)
// config    | cfg_we                  | cfg_index, cfg_data (map width/height)
//
// a dropped event ends in the check state; a miss scans every filled slot, and a hit ends
// the scan at its slot: the tag scan reads one slot per cycle from the slot memory
// the result strobe comes in the same cycle that busy falls; a new event may start then.
// rst_n clears the fill count and the fifo pointer and sets the map registers to 64 x 64;
// the slot memory is not cleared: slots at or above the fill count are never compared.
// the receiver cannot stall: done is high for a single cycle; res holds until the next event.

module tile_marker_fifo_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tmft_pkg::ev_t               ev,
    output logic                        done,
    output tmft_pkg::res_t              res,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [tmft_pkg::MAP_W-1:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;

    logic [1:0] state_reg, state_next;

    // configuration
    logic [tmft_pkg::MAP_W-1:0] map_w_reg, map_h_reg;

    // latched event word
    tmft_pkg::ev_t ev_reg;

    // table bookkeeping
    logic [tmft_pkg::CNT_W-1:0]  filled_reg, filled_next;
    logic [tmft_pkg::SLOT_W-1:0] oldest_reg, oldest_next;

    // scan pipeline: read issued at rd_idx, compared in the cycle after at cmp_idx
    logic [tmft_pkg::CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [tmft_pkg::SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic                        rd_vld_reg, rd_vld_next;

    // result word
    tmft_pkg::res_t res_reg, res_next;
    logic           done_reg, done_next;

    // slot memory ports
    logic                        ram_we;
    logic [tmft_pkg::SLOT_W-1:0] ram_waddr;
    tmft_pkg::slot_entry_t       ram_wdata;
    tmft_pkg::slot_entry_t       ram_rdata;

    // event decode
    logic [tmft_pkg::TILE_BITS-1:0] ev_tx, ev_ty;
    logic                           ev_on_map;
    logic                           issue;
    logic                           match;
    logic                           table_full;

    assign ev_tx     = ev_reg.pos_x[tmft_pkg::POS_SHIFT +: tmft_pkg::TILE_BITS];
    assign ev_ty     = ev_reg.pos_y[tmft_pkg::POS_SHIFT +: tmft_pkg::TILE_BITS];
    assign ev_on_map = tmft_pkg::on_map(ev_reg.pos_x, map_w_reg)
                    && tmft_pkg::on_map(ev_reg.pos_y, map_h_reg);

    assign issue      = rd_idx_reg < filled_reg;
    assign match      = rd_vld_reg && (ram_rdata.tag_x == ev_tx)
                                   && (ram_rdata.tag_y == ev_ty);
    assign table_full = filled_reg == tmft_pkg::CNT_W'(tmft_pkg::SLOTS);

    tmft_ram #(
        .WIDTH ($bits(tmft_pkg::slot_entry_t)),
        .DEPTH (tmft_pkg::SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[tmft_pkg::SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        filled_next  = filled_reg;
        oldest_next  = oldest_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        rd_vld_next  = 1'b0;
        res_next     = res_reg;
        done_next    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cmp_idx_reg;
        ram_wdata    = ram_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                // drop checks; tile numbers reported unless off the map
                res_next.slot_index = '0;
                res_next.variant    = '0;
                res_next.tile_x     = 12'(ev_tx);
                res_next.tile_y     = 12'(ev_ty);
                rd_idx_next         = '0;
                if (!ev_on_map)
                begin
                    res_next.outcome = tmft_pkg::OUT_OFF_MAP;
                    res_next.tile_x  = '0;
                    res_next.tile_y  = '0;
                    done_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
                else if (ev_reg.chance_value >= tmft_pkg::CHANCE_LIMIT)
                begin
                    res_next.outcome = tmft_pkg::OUT_CHANCE;
                    done_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
                else if ((ev_reg.tile_flags & tmft_pkg::BLOCK_MASK) != 8'd0)
                begin
                    res_next.outcome = tmft_pkg::OUT_BLOCKED;
                    done_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (match)
                begin
                    // hit: bump the variant in place, order unchanged
                    ram_we            = 1'b1;
                    ram_waddr         = cmp_idx_reg;
                    ram_wdata.variant = 3'(ram_rdata.variant + 3'd1);
                    res_next.outcome    = tmft_pkg::OUT_HIT;
                    res_next.slot_index = 6'(cmp_idx_reg);
                    res_next.variant    = 3'(ram_rdata.variant + 3'd1);
                    done_next           = 1'b1;
                    state_next          = ST_IDLE;
                end
                else if (issue)
                begin
                    rd_vld_next  = 1'b1;
                    cmp_idx_next = rd_idx_reg[tmft_pkg::SLOT_W-1:0];
                    rd_idx_next  = rd_idx_reg + tmft_pkg::CNT_W'(1);
                end
                else
                begin
                    // miss: with a sprite, fill in order; when full, reuse the oldest slot
                    ram_wdata.tag_x   = ev_tx;
                    ram_wdata.tag_y   = ev_ty;
                    ram_wdata.variant = ev_reg.chance_value[2:0];
                    res_next.variant  = ev_reg.chance_value[2:0];
                    done_next         = 1'b1;
                    state_next        = ST_IDLE;
                    if (table_full)
                    begin
                        ram_we              = 1'b1;
                        ram_waddr           = oldest_reg;
                        res_next.outcome    = tmft_pkg::OUT_RECYCLE;
                        res_next.slot_index = 6'(oldest_reg);
                        oldest_next = (oldest_reg == tmft_pkg::SLOT_W'(tmft_pkg::SLOTS - 1))
                                    ? '0 : oldest_reg + tmft_pkg::SLOT_W'(1);
                    end
                    else if (!ev_reg.sprite_available)
                    begin
                        res_next.outcome    = tmft_pkg::OUT_NO_SPRITE;
                        res_next.slot_index = '0;
                        res_next.variant    = '0;
                    end
                    else
                    begin
                        ram_we              = 1'b1;
                        ram_waddr           = filled_reg[tmft_pkg::SLOT_W-1:0];
                        res_next.outcome    = tmft_pkg::OUT_NEW;
                        res_next.slot_index = 6'(filled_reg);
                        filled_next         = filled_reg + tmft_pkg::CNT_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            filled_reg <= '0;
            oldest_reg <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            map_w_reg  <= tmft_pkg::MAP_W'(64);
            map_h_reg  <= tmft_pkg::MAP_W'(64);
        end
        else
        begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            oldest_reg <= oldest_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tmft_pkg::CFG_MAP_WIDTH:  map_w_reg <= cfg_data;
                    tmft_pkg::CFG_MAP_HEIGHT: map_h_reg <= cfg_data;
                    default:                  map_w_reg <= map_w_reg;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (start && (state_reg == ST_IDLE))
        begin
            ev_reg <= ev;
        end
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    assign busy = state_reg != ST_IDLE;
    assign done = done_reg;
    assign res  = res_reg;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an event in work");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= tmft_pkg::CNT_W'(tmft_pkg::SLOTS))
        else $error("fill count beyond table size");

    a_oldest_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (oldest_reg != $past(oldest_reg)) |-> table_full)
        else $error("fifo pointer moved before table filled");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && (res.outcome == tmft_pkg::OUT_HIT || res.outcome == tmft_pkg::OUT_NEW
                 || res.outcome == tmft_pkg::OUT_RECYCLE)
        |-> (res.slot_index < 6'(tmft_pkg::SLOTS)))
        else $error("slot index out of range");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> !ram_we)
        else $error("two table writes for one event");
`endif

endmodule
